/* src/ggc_pkg.sv */
package ggc_pkg;

	localparam int VTX_W = 12;
	localparam int COLOR_W = 6;
	localparam int CNT_W = 7;
	localparam int EPOCH_W = 8;
	localparam int VTX_SPACE = 1 << VTX_W;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int MAX_COLORS_DEF = 64;

	// Last graph tag before a clearing pass is needed.
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic [VTX_W-1:0] neighbor;
		logic             has_neighbor;
		logic             last_of_vertex;
		logic             new_graph;
	} item_t;

	typedef struct packed {
		logic [VTX_W-1:0]   colored_vertex;
		logic [COLOR_W-1:0] assigned_color;
		logic [CNT_W-1:0]   colors_used;
		logic               overflow;
	} res_t;

	// One word per vertex: graph tag, colored mark, color.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic               mark;
		logic [COLOR_W-1:0] color;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [VTX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

endpackage

/* src/ggc_in_if.sv */
interface ggc_in_if
	import ggc_pkg::*;
();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/ggc_out_if.sv */
interface ggc_out_if
	import ggc_pkg::*;
();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/greedy_graph_coloring_unit.sv */
// Channel | Dir | Handshake     | Payload
// item    | in  | valid / ready | vertex, neighbor, has_neighbor, last_of_vertex, new_graph
// result  | out | valid / ready | colored_vertex, assigned_color, colors_used, overflow
//
// One item per cycle while ready is high: the color memory is read when the item is
// accepted and the mask update, color pick and write-back happen in the next cycle.
// A result follows its last item through the stage register and the output buffer.
// After reset a clearing pass over min(MAX_VERTICES, 4096) entries holds ready low.
// It reruns at each graph tag wrap (new_graph item 256, then every 255th).
// Ready also drops while four results are held or in flight toward the output buffer.
module greedy_graph_coloring_unit
	import ggc_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_COLORS   = MAX_COLORS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ggc_in_if.sink  item,
	ggc_out_if.source result
);

	// Only the first 4096 vertices are addressable by the 12-bit fields.
	localparam int MEM_DEPTH = (MAX_VERTICES < VTX_SPACE) ? MAX_VERTICES : VTX_SPACE;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [VTX_W:0] VTX_LIMIT = (VTX_W + 1)'(MEM_DEPTH);

	logic                  accept;
	logic                  mem_busy;
	logic                  clr_start;
	entry_t                rd_data;
	mem_wr_t               wr;

	logic [EPOCH_W-1:0]    epoch_q;

	logic                  valid_s1;
	item_t                 item_s1;
	logic [EPOCH_W-1:0]    epoch_s1;
	logic                  nb_ok_s1;

	logic                  fwd_valid_q;
	logic [AW-1:0]         fwd_addr_q;
	entry_t                fwd_data_q;

	logic [MAX_COLORS-1:0] mask_q;
	logic [CNT_W-1:0]      in_use_q;

	entry_t                ent;
	logic                  nb_colored;
	logic [MAX_COLORS-1:0] mask_now;
	logic [CNT_W-1:0]      in_use_base;
	logic [COLOR_W-1:0]    chosen;
	logic [CNT_W-1:0]      in_use_next;
	logic                  ovf;
	logic                  vtx_ok;

	logic                  push;
	res_t                  push_data;
	logic [RES_CNT_W-1:0]  fifo_count;
	logic [RES_CNT_W-1:0]  inflight;

	// Input side: credit against the result buffer, hold off during clearing,
	// and hold a new graph back when the tag must wrap.
	assign inflight   = fifo_count + RES_CNT_W'(valid_s1 && item_s1.last_of_vertex);
	assign item.ready = !mem_busy && (inflight < RES_CNT_W'(RES_DEPTH))
		&& !(item.data.new_graph && (epoch_q == EPOCH_MAX));
	assign accept     = item.valid && item.ready;
	assign clr_start  = item.valid && item.data.new_graph && (epoch_q == EPOCH_MAX)
		&& !valid_s1 && !mem_busy;

	ggc_color_mem #(
		.DEPTH (MEM_DEPTH)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_start (clr_start),
		.busy        (mem_busy),
		.rd_addr     (item.data.neighbor[AW-1:0]),
		.rd_data     (rd_data),
		.wr          (wr)
	);

	// Graph tag advances per new graph, zeroed on a clear; the stage carries its own tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			mask_q      <= '0;
			in_use_q    <= '0;
		end else begin
			if (clr_start) begin
				epoch_q <= '0;
			end else if (accept && item.data.new_graph) begin
				epoch_q <= epoch_q + 1'b1;
			end
			valid_s1    <= accept;
			fwd_valid_q <= wr.en;
			if (valid_s1) begin
				if (item_s1.last_of_vertex) begin
					mask_q   <= '0;
					in_use_q <= in_use_next;
				end else begin
					mask_q   <= mask_now;
					in_use_q <= in_use_base;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1  <= item.data;
			epoch_s1 <= item.data.new_graph ? epoch_q + 1'b1 : epoch_q;
			nb_ok_s1 <= item.data.has_neighbor && ({1'b0, item.data.neighbor} < VTX_LIMIT);
		end
		fwd_addr_q <= wr.addr[AW-1:0];
		fwd_data_q <= wr.data;
	end

	// Forward last cycle's write: the memory read issued alongside it saw old data.
	always_comb begin
		ent = rd_data;
		if (fwd_valid_q && (fwd_addr_q == item_s1.neighbor[AW-1:0])) begin
			ent = fwd_data_q;
		end
		nb_colored  = nb_ok_s1 && ent.mark && (ent.epoch == epoch_s1);
		in_use_base = item_s1.new_graph ? '0 : in_use_q;
		mask_now    = item_s1.new_graph ? '0 : mask_q;
		for (int c = 0; c < MAX_COLORS; c++) begin
			if (nb_colored && (ent.color == COLOR_W'(c))) begin
				mask_now[c] = 1'b1;
			end
		end
	end

	ggc_first_fit #(
		.MAX_COLORS (MAX_COLORS)
	) u_pick (
		.forbid      (mask_now),
		.in_use      (in_use_base),
		.chosen      (chosen),
		.in_use_next (in_use_next),
		.overflow    (ovf)
	);

	// Store the pick; an overflow drops the vertex's mark.
	assign vtx_ok          = ({1'b0, item_s1.vertex} < VTX_LIMIT);
	assign wr.en           = valid_s1 && item_s1.last_of_vertex && vtx_ok;
	assign wr.addr         = item_s1.vertex;
	assign wr.data.epoch   = epoch_s1;
	assign wr.data.mark    = !ovf;
	assign wr.data.color   = chosen;

	assign push                     = valid_s1 && item_s1.last_of_vertex;
	assign push_data.colored_vertex = item_s1.vertex;
	assign push_data.assigned_color = chosen;
	assign push_data.colors_used    = in_use_next;
	assign push_data.overflow       = ovf;

	ggc_result_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (fifo_count),
		.result    (result)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !item.ready)
		else $error("item accepted during clearing pass");

	a_clear_resets_tag: assert property (@(posedge clk) disable iff (!arst_n)
		clr_start |=> (epoch_q == '0) && mem_busy)
		else $error("clearing pass did not restart the graph tag");

	a_room_for_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_count < RES_CNT_W'(RES_DEPTH)))
		else $error("result pushed into a full buffer");

	a_mask_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_of_vertex) |=> (mask_q == '0))
		else $error("forbidden mask kept after vertex end");

endmodule

/* src/ggc_color_mem.sv */
module ggc_color_mem
	import ggc_pkg::*;
#(
	parameter int DEPTH = MAX_VERTICES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_start,
	output logic          busy,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  mem_wr_t       wr
);

	typedef enum logic {ST_CLEAR, ST_RUN} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	entry_t        mem [DEPTH];
	entry_t        rd_data_q;

	// Sweep every entry to tag zero, unmarked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q   <= ST_RUN;
						clr_cnt_q <= '0;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (clear_start) begin
						state_q <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign busy = (state_q == ST_CLEAR);

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* src/ggc_first_fit.sv */
module ggc_first_fit
	import ggc_pkg::*;
#(
	parameter int MAX_COLORS = MAX_COLORS_DEF
) (
	input  logic [MAX_COLORS-1:0] forbid,
	input  logic [CNT_W-1:0]      in_use,
	output logic [COLOR_W-1:0]    chosen,
	output logic [CNT_W-1:0]      in_use_next,
	output logic                  overflow
);

	logic [MAX_COLORS-1:0] avail;
	logic                  found;

	always_comb begin
		avail       = '0;
		found       = 1'b0;
		chosen      = '0;
		in_use_next = in_use;
		overflow    = 1'b0;
		for (int c = 0; c < MAX_COLORS; c++) begin
			avail[c] = !forbid[c] && (CNT_W'(c) < in_use);
		end
		// Lowest free color wins: scan from the top down.
		for (int c = MAX_COLORS - 1; c >= 0; c--) begin
			if (avail[c]) begin
				chosen = COLOR_W'(c);
				found  = 1'b1;
			end
		end
		if (!found) begin
			if (in_use < CNT_W'(MAX_COLORS)) begin
				chosen      = in_use[COLOR_W-1:0];
				in_use_next = in_use + 1'b1;
			end else begin
				overflow = 1'b1;
			end
		end
	end

endmodule

/* src/ggc_result_fifo.sv */
module ggc_result_fifo
	import ggc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  res_t                 push_data,
	output logic [RES_CNT_W-1:0] count,
	ggc_out_if.source            result
);

	res_t                 buf_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 pop;

	assign pop          = result.valid && result.ready;
	assign result.valid = (count_q != '0);
	assign result.data  = buf_q[rd_ptr_q];
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
